// ===== hdl/ppe_pkg.sv =====
// Shared types and constants for the pivot partition engine.
package ppe_pkg;

  localparam int DataW           = 32;
  localparam int PosW            = 6;
  localparam int MaxElemsDefault = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SCAN_START,
    ST_RIGHT,
    ST_LEFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT
  } ppe_state_e;

  typedef struct packed {
    logic                    we;
    logic [PosW-1:0]         waddr;
    logic signed [DataW-1:0] wdata;
    logic                    re;
    logic [PosW-1:0]         raddr;
  } ppe_mem_req_t;

endpackage

// ===== hdl/pivot_partition_engine_core.sv =====
// Top level of the pivot partition engine: sequencer, element store, checks.
// Load: one element request per cycle while in the load state. After the last request the list of n
// elements goes through the first/last exchange (SWAP_A, SWAP_B, SCAN_START), one store read per
// scan step (n-1 steps at most), a state to place the pivot and one to prime the read, then one
// result per cycle while the receiver is ready.
// Reset clears the sequencer, count and overflow flag; store contents stay undefined.
module pivot_partition_engine_core #(
  parameter int MAX_ELEMS = ppe_pkg::MaxElemsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              element_valid_i,
  output logic                              element_ready_o,
  input  logic signed [ppe_pkg::DataW-1:0]  element_value_i,
  input  logic                              last_element_i,
  output logic                              result_valid_o,
  input  logic                              result_ready_i,
  output logic signed [ppe_pkg::DataW-1:0]  result_value_o,
  output logic [ppe_pkg::PosW-1:0]          result_position_o,
  output logic [ppe_pkg::PosW-1:0]          pivot_position_o,
  output logic                              overflowed_o,
  output logic                              last_result_o
);

  ppe_pkg::ppe_mem_req_t             mem_req;
  logic signed [ppe_pkg::DataW-1:0]  rd_data;

  // Sequencer: stores requests, runs the hole-filling scans, streams results.
  ppe_ctrl #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .element_valid_i  (element_valid_i),
    .element_ready_o  (element_ready_o),
    .element_value_i  (element_value_i),
    .last_element_i   (last_element_i),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .result_value_o   (result_value_o),
    .result_position_o(result_position_o),
    .pivot_position_o (pivot_position_o),
    .overflowed_o     (overflowed_o),
    .last_result_o    (last_result_o),
    .mem_req_o        (mem_req),
    .rd_data_i        (rd_data)
  );

  // Element store, one entry per list slot.
  ppe_mem #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  // Loading and emitting never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(element_ready_o && result_valid_o))
    else $error("input ready while results pending");

  // The final request of a list closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    element_valid_i && element_ready_o && last_element_i |=> !element_ready_o)
    else $error("input still open after last element");

  // A run continues without gaps and with consecutive positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && !last_result_o |=>
      result_valid_o && (result_position_o == $past(result_position_o) + 6'd1))
    else $error("result run broken");

  // Pivot position holds across a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && !last_result_o |=> $stable(pivot_position_o))
    else $error("pivot position moved during run");

endmodule

// ===== hdl/ppe_mem.sv =====
// Element store: one write port, one read port, registered read data.
module ppe_mem #(
  parameter int MAX_ELEMS = ppe_pkg::MaxElemsDefault
) (
  input  logic                                  clk_i,
  input  ppe_pkg::ppe_mem_req_t                 req_i,
  output logic signed [ppe_pkg::DataW-1:0]      rd_data_o
);

  localparam int AW = $clog2(MAX_ELEMS);

  logic signed [ppe_pkg::DataW-1:0] mem_q [MAX_ELEMS];
  logic signed [ppe_pkg::DataW-1:0] rd_data_q;

  // A read of the entry written in the same cycle returns the old data.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/ppe_ctrl.sv =====
// Load, partition and emit sequencer around the element store.
module ppe_ctrl #(
  parameter int MAX_ELEMS = ppe_pkg::MaxElemsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 element_valid_i,
  output logic                                 element_ready_o,
  input  logic signed [ppe_pkg::DataW-1:0]     element_value_i,
  input  logic                                 last_element_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic signed [ppe_pkg::DataW-1:0]     result_value_o,
  output logic [ppe_pkg::PosW-1:0]             result_position_o,
  output logic [ppe_pkg::PosW-1:0]             pivot_position_o,
  output logic                                 overflowed_o,
  output logic                                 last_result_o,
  output ppe_pkg::ppe_mem_req_t                mem_req_o,
  input  logic signed [ppe_pkg::DataW-1:0]     rd_data_i
);

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  ppe_pkg::ppe_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] last_idx_q, last_idx_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] emit_idx_q, emit_idx_d;
  logic signed [ppe_pkg::DataW-1:0] pivot_q, pivot_d;

  logic          in_fire, out_fire, has_room;
  logic          gt_pivot, lt_pivot;
  logic [AW-1:0] lo_p1, hi_m1;
  logic          emit_last;

  assign in_fire   = element_valid_i && element_ready_o;
  assign out_fire  = result_valid_o && result_ready_i;
  assign has_room  = count_q < CW'(MAX_ELEMS);
  assign gt_pivot  = rd_data_i > pivot_q;
  assign lt_pivot  = rd_data_i < pivot_q;
  assign lo_p1     = lo_q + AW'(1);
  assign hi_m1     = hi_q - AW'(1);
  assign emit_last = emit_idx_q == last_idx_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppe_pkg::ST_LOAD: begin
        if (in_fire && last_element_i) state_d = ppe_pkg::ST_SWAP_A;
      end
      ppe_pkg::ST_SWAP_A:     state_d = ppe_pkg::ST_SWAP_B;
      ppe_pkg::ST_SWAP_B:     state_d = ppe_pkg::ST_SCAN_START;
      ppe_pkg::ST_SCAN_START: begin
        state_d = (hi_q > lo_q) ? ppe_pkg::ST_RIGHT : ppe_pkg::ST_PLACE;
      end
      ppe_pkg::ST_RIGHT: begin
        if (gt_pivot) begin
          state_d = (hi_m1 > lo_q) ? ppe_pkg::ST_RIGHT : ppe_pkg::ST_PLACE;
        end else begin
          state_d = (lo_p1 < hi_q) ? ppe_pkg::ST_LEFT : ppe_pkg::ST_PLACE;
        end
      end
      ppe_pkg::ST_LEFT: begin
        if (lt_pivot) begin
          state_d = (lo_p1 < hi_q) ? ppe_pkg::ST_LEFT : ppe_pkg::ST_PLACE;
        end else begin
          state_d = (hi_m1 > lo_q) ? ppe_pkg::ST_RIGHT : ppe_pkg::ST_PLACE;
        end
      end
      ppe_pkg::ST_PLACE:      state_d = ppe_pkg::ST_EMIT_RD;
      ppe_pkg::ST_EMIT_RD:    state_d = ppe_pkg::ST_EMIT;
      ppe_pkg::ST_EMIT: begin
        if (out_fire && emit_last) state_d = ppe_pkg::ST_LOAD;
      end
      default:                state_d = ppe_pkg::ST_LOAD;
    endcase
  end

  // Memory requests, pointer moves and handshake outputs.
  always_comb begin
    count_d         = count_q;
    ovf_d           = ovf_q;
    last_idx_d      = last_idx_q;
    lo_d            = lo_q;
    hi_d            = hi_q;
    emit_idx_d      = emit_idx_q;
    pivot_d         = pivot_q;
    mem_req_o       = '0;
    element_ready_o = 1'b0;
    result_valid_o  = 1'b0;
    unique case (state_q)
      ppe_pkg::ST_LOAD: begin
        element_ready_o = 1'b1;
        if (in_fire) begin
          if (has_room) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ppe_pkg::PosW'(count_q);
            mem_req_o.wdata = element_value_i;
            count_d         = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_element_i) begin
            last_idx_d = has_room ? count_q[AW-1:0] : AW'(MAX_ELEMS - 1);
            lo_d       = '0;
            hi_d       = has_room ? count_q[AW-1:0] : AW'(MAX_ELEMS - 1);
          end
        end
      end
      ppe_pkg::ST_SWAP_A: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = '0;
      end
      ppe_pkg::ST_SWAP_B: begin
        // Old first element moves to the last slot; read the last slot as pivot.
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ppe_pkg::PosW'(last_idx_q);
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ppe_pkg::PosW'(last_idx_q);
        mem_req_o.wdata = rd_data_i;
      end
      ppe_pkg::ST_SCAN_START: begin
        pivot_d         = rd_data_i;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ppe_pkg::PosW'(hi_q);
      end
      ppe_pkg::ST_RIGHT: begin
        if (gt_pivot) begin
          hi_d            = hi_m1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ppe_pkg::PosW'(hi_m1);
        end else begin
          // Fill the hole at lo, then scan from the left.
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ppe_pkg::PosW'(lo_q);
          mem_req_o.wdata = rd_data_i;
          lo_d            = lo_p1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ppe_pkg::PosW'(lo_p1);
        end
      end
      ppe_pkg::ST_LEFT: begin
        if (lt_pivot) begin
          lo_d            = lo_p1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ppe_pkg::PosW'(lo_p1);
        end else begin
          // Fill the hole at hi, then scan from the right.
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ppe_pkg::PosW'(hi_q);
          mem_req_o.wdata = rd_data_i;
          hi_d            = hi_m1;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ppe_pkg::PosW'(hi_m1);
        end
      end
      ppe_pkg::ST_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ppe_pkg::PosW'(lo_q);
        mem_req_o.wdata = pivot_q;
        emit_idx_d      = '0;
      end
      ppe_pkg::ST_EMIT_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ppe_pkg::PosW'(emit_idx_q);
      end
      ppe_pkg::ST_EMIT: begin
        result_valid_o = 1'b1;
        if (out_fire) begin
          if (emit_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            emit_idx_d      = emit_idx_q + AW'(1);
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ppe_pkg::PosW'(emit_idx_q + AW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppe_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_idx_q <= last_idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    emit_idx_q <= emit_idx_d;
    pivot_q    <= pivot_d;
  end

  assign result_value_o    = rd_data_i;
  assign result_position_o = ppe_pkg::PosW'(emit_idx_q);
  assign pivot_position_o  = ppe_pkg::PosW'(lo_q);
  assign overflowed_o      = ovf_q;
  assign last_result_o     = emit_last;

endmodule

// ===== tb/pivot_partition_engine_core_tb.sv =====
// Testbench for pivot_partition_engine_core: directed and random lists checked against a partition predictor.
module pivot_partition_engine_core_tb;

  localparam int DataW        = ppe_pkg::DataW;
  localparam int PosW         = ppe_pkg::PosW;
  localparam int MaxElems     = ppe_pkg::MaxElemsDefault;
  localparam int CycleLimit   = 200000;
  localparam int HoldoffLen   = 400;   // long receiver stall, in cycles
  localparam int HoldoffAfter = 40;    // results seen before the stall starts
  localparam int QuietFrom    = 600;   // window with no idling on either side
  localparam int QuietTo      = 1100;
  localparam int RandomItems  = 280;   // random element requests, directed lists come on top
  localparam int MidPauseAt   = 200;   // random requests queued before the second drain pause
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};

  // One element request waiting to be offered to the block.
  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    bit                      drain_first;  // wait until all results are out first
  } element_request_t;

  // One partitioned element as the block should emit it.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
    logic [PosW-1:0]         pivot_pos;
    logic                    overflowed;
    logic                    last;
  } partition_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    element_valid = 1'b0;
  logic signed [DataW-1:0] element_value = '0;
  logic                    last_element = 1'b0;
  logic                    result_ready = 1'b0;

  logic                    element_ready_o;
  logic                    result_valid_o;
  logic signed [DataW-1:0] result_value_o;
  logic [PosW-1:0]         result_position_o;
  logic [PosW-1:0]         pivot_position_o;
  logic                    overflowed_o;
  logic                    last_result_o;

  element_request_t  pending_requests[$];
  partition_result_t expected_results[$];

  // Predictor state: the list being collected.
  logic signed [DataW-1:0] list_store [MaxElems];
  int                      list_count;
  bit                      list_dropped;

  int cycle_count;
  int error_count;
  int requests_sent;
  int results_checked;
  int lists_done;
  int overflow_lists;
  int holdoff_left;
  bit holdoff_done;

  pivot_partition_engine_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .element_valid_i   (element_valid),
    .element_ready_o   (element_ready_o),
    .element_value_i   (element_value),
    .last_element_i    (last_element),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready),
    .result_value_o    (result_value_o),
    .result_position_o (result_position_o),
    .pivot_position_o  (pivot_position_o),
    .overflowed_o      (overflowed_o),
    .last_result_o     (last_result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Store one accepted element; on the last mark, partition the list the way the
  // hole-filling scheme does and queue one expected result per stored element.
  task automatic accept_element(input logic signed [DataW-1:0] value, input logic last);
    int lo;
    int hi;
    logic signed [DataW-1:0] pivot;
    partition_result_t res;
    if (list_count < MaxElems) begin
      list_store[list_count] = value;
      list_count++;
    end else begin
      // Store full: drop the element, even when it carries the last mark.
      list_dropped = 1'b1;
    end
    if (!last) return;
    // Swap first and last, then take the new first as pivot.
    lo = 0;
    hi = list_count - 1;
    pivot = list_store[hi];
    list_store[hi] = list_store[lo];
    list_store[lo] = pivot;
    while (lo != hi) begin
      while (hi > lo && list_store[hi] > pivot) hi--;
      if (lo < hi) begin
        list_store[lo] = list_store[hi];
        lo++;
      end
      while (lo < hi && list_store[lo] < pivot) lo++;
      if (lo < hi) begin
        list_store[hi] = list_store[lo];
        hi--;
      end
    end
    list_store[lo] = pivot;
    for (int k = 0; k < list_count; k++) begin
      res.value      = list_store[k];
      res.position   = PosW'(k);
      res.pivot_pos  = PosW'(lo);
      res.overflowed = list_dropped;
      res.last       = (k == list_count - 1);
      expected_results.push_back(res);
    end
    lists_done++;
    if (list_dropped) overflow_lists++;
    list_count   = 0;
    list_dropped = 1'b0;
  endtask

  // Roll the random idle for one cycle; never idle inside the quiet window.
  function automatic bit idle_roll();
    if (cycle_count >= QuietFrom && cycle_count < QuietTo) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  // Mix full-range values with extremes and a narrow band that makes many
  // duplicates and elements equal to the pivot.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MinVal;
      1:       return MaxVal;
      2, 3, 4: return DataW'(int'($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_element(input logic signed [DataW-1:0] value, input logic last,
                              input bit drain_first);
    element_request_t req;
    req.value       = value;
    req.last        = last;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
  endtask

  task automatic push_list(input logic signed [DataW-1:0] vals[$]);
    foreach (vals[i]) push_element(vals[i], i == vals.size() - 1, 1'b0);
  endtask

  task automatic push_random_list(input int n, input bit drain_first);
    for (int i = 0; i < n; i++) push_element(pick_value(), i == n - 1, drain_first && i == 0);
  endtask

  // Driver: offer the next request, hold it steady until the block takes it.
  always @(posedge clk_i) begin
    element_request_t nxt;
    logic taken;
    taken = element_valid && element_ready_o;
    if (!rst_ni) begin
      element_valid <= 1'b0;
    end else begin
      if (taken) begin
        accept_element(element_value, last_element);
        requests_sent++;
      end
      if (element_valid && !taken) begin
        // hold the current request
      end else if (pending_requests.size() == 0 || idle_roll() ||
                   (pending_requests[0].drain_first && expected_results.size() != 0)) begin
        element_valid <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        element_value <= nxt.value;
        last_element  <= nxt.last;
        element_valid <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [DataW-1:0] expv,
                             input logic [DataW-1:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
      error_count++;
    end
  endtask

  // Monitor and receiver: check each accepted result, then pick the next ready.
  always @(posedge clk_i) begin
    partition_result_t exp_res;
    if (!rst_ni) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid_o && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: value %0h position %0d",
                 result_value_o, result_position_o);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("result_value", exp_res.value, result_value_o);
          check_field("result_position", DataW'(exp_res.position), DataW'(result_position_o));
          check_field("pivot_position", DataW'(exp_res.pivot_pos), DataW'(pivot_position_o));
          check_field("overflowed", DataW'(exp_res.overflowed), DataW'(overflowed_o));
          check_field("last_result", DataW'(exp_res.last), DataW'(last_result_o));
        end
        results_checked++;
      end
      // Stall once for a long stretch so the block backs up into its input.
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_ready <= 1'b0;
      end else if (!holdoff_done && results_checked >= HoldoffAfter) begin
        holdoff_done = 1'b1;
        holdoff_left = HoldoffLen;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !idle_roll();
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [DataW-1:0] dir_list[$];
    int random_count;
    int n;
    bit mid_pause_done;

    // Directed lists: single element, extremes, all equal, sorted, reversed, pair.
    dir_list = '{MinVal};
    push_list(dir_list);
    dir_list = '{MaxVal, MinVal, 0, -1, 1};
    push_list(dir_list);
    dir_list = '{7, 7, 7, 7};
    push_list(dir_list);
    dir_list = '{-3, -2, -1, 0, 1, 2};
    push_list(dir_list);
    dir_list = '{5, 3, 1, -1};
    push_list(dir_list);
    dir_list = '{2, 1};
    push_list(dir_list);

    // Random lists: first a full store after a drain pause, then one whose
    // last request is dropped, then mostly short lists with a few long ones.
    random_count = 0;
    mid_pause_done = 1'b0;
    push_random_list(MaxElems, 1'b1);
    push_random_list(MaxElems + 2, 1'b0);
    random_count = 2 * MaxElems + 2;
    while (random_count < RandomItems) begin
      case ($urandom_range(19))
        0:          n = $urandom_range(MaxElems + 6, MaxElems - 4);
        1, 2:       n = $urandom_range(40, 13);
        default:    n = $urandom_range(12, 1);
      endcase
      push_random_list(n, !mid_pause_done && random_count >= MidPauseAt);
      if (random_count >= MidPauseAt) mid_pause_done = 1'b1;
      random_count += n;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || element_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d element requests in %0d lists (%0d with dropped elements).",
             requests_sent, lists_done, overflow_lists);
    $display("Checked %0d partitioned results in %0d cycles, %0d errors.",
             results_checked, cycle_count, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ppe_pkg.sv
hdl/ppe_mem.sv
hdl/ppe_ctrl.sv
hdl/pivot_partition_engine_core.sv
tb/pivot_partition_engine_core_tb.sv
